// ===== src/section_file_header_checker_core_defines.svh =====
// ----------------------------------------------------------------------------
// Section file header checker - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SECTION_FILE_HEADER_CHECKER_CORE_DEFINES_SVH
`define SECTION_FILE_HEADER_CHECKER_CORE_DEFINES_SVH

// Condition holds at every clock edge outside reset
`define SFHC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define SFHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define SFHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sfhc_pkg.sv =====
// ----------------------------------------------------------------------------
// Section file header checker - package
// Register indexes, status codes, reset values and result item layout.
// ----------------------------------------------------------------------------
package sfhc_pkg;

  // Header and record geometry
  localparam int unsigned HDR_BYTES = 9;
  localparam int unsigned REC_BYTES = 22;

  // Result queue depth (two results may be pushed per input byte)
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Register reset values
  localparam logic [31:0] MAGIC_RST       = 32'h3074_6851;
  localparam logic [15:0] VERSION_MIN_RST = 16'd86;
  localparam logic [15:0] VERSION_MAX_RST = 16'd129;
  localparam logic [7:0]  SECTION_MIN_RST = 8'd2;
  localparam logic [7:0]  SECTION_MAX_RST = 8'd12;
  localparam logic [31:0] SIZE_LIMIT_RST  = 32'd1143;

  // Allowed section types
  localparam logic [15:0] TYPE_A = 16'd68;
  localparam logic [15:0] TYPE_B = 16'd92;
  localparam logic [15:0] TYPE_C = 16'd36;
  localparam logic [15:0] TYPE_D = 16'd57;
  localparam logic [15:0] TYPE_E = 16'd91;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MAGIC       = 3'd0,
    REG_VERSION_MIN = 3'd1,
    REG_VERSION_MAX = 3'd2,
    REG_SECTION_MIN = 3'd3,
    REG_SECTION_MAX = 3'd4,
    REG_SIZE_LIMIT  = 3'd5
  } sfhc_reg_t;

  // Verdict codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_MAGIC     = 3'd2,
    ST_VERSION   = 3'd3,
    ST_COUNT     = 3'd4,
    ST_HDR_SIZE  = 3'd5,
    ST_TYPE      = 3'd6
  } sfhc_status_t;

  // Result kind (travels on tuser)
  typedef enum logic {
    KIND_SECTION = 1'b0,
    KIND_VERDICT = 1'b1
  } sfhc_kind_t;

  // Result payload, last field in the lowest bits
  typedef struct packed {
    logic         sizes_within_limit;
    logic [7:0]   section_total;
    logic [15:0]  file_version;
    sfhc_status_t status;
    logic [31:0]  section_length;
    logic [31:0]  section_start;
    logic [15:0]  section_kind;
    logic [7:0]   section_number;
  } sfhc_payload_t;

  localparam int unsigned PAYLOAD_W = $bits(sfhc_payload_t);
  localparam int unsigned TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;
  localparam int unsigned PAD_W     = TDATA_W - PAYLOAD_W;

  // One queued result
  typedef struct packed {
    sfhc_kind_t    kind;
    logic          last;
    sfhc_payload_t data;
  } sfhc_entry_t;

  // Section type whitelist
  function automatic logic type_allowed(input logic [15:0] t);
    return (t == TYPE_A) || (t == TYPE_B) || (t == TYPE_C) ||
           (t == TYPE_D) || (t == TYPE_E);
  endfunction

endpackage

// ===== src/section_file_header_checker_core.sv =====
// Results caused by a byte are pushed into the result queue and offered on out_* from there.
// One byte per cycle while in_tready is high; a byte causing two results queues both, popped one at a time.
// in_tready falls when fewer than two slots of the 4-entry result queue are free.
// Reset (rst_n low, synchronous): registers return to defaults, queue empties,
// and bytes are ignored until one arrives with the start-of-file flag (in_tuser).
// ----------------------------------------------------------------------------
// Section file header checker
// Parses a byte stream: 9-byte header check, then 22-byte section records,
// emitting one item per record and a final verdict item.
// ----------------------------------------------------------------------------
`include "section_file_header_checker_core_defines.svh"

module section_file_header_checker_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input bytes
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] data_byte
  input  logic                        in_tuser,   // [0] first_byte
  input  logic                        in_tlast,   // final_byte
  // Result items
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [7:0] section_number, [23:8] section_kind, [55:24] section_start,
  // [87:56] section_length, [90:88] status, [106:91] file_version,
  // [114:107] section_total, [115] sizes_within_limit, [119:116] zero
  output logic [sfhc_pkg::TDATA_W-1:0] out_tdata,
  output logic                        out_tuser,  // [0] record_kind
  output logic                        out_tlast,  // last_of_run
  // Configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [31:0]                 cfg_data
);

  import sfhc_pkg::*;

  // Configuration registers
  logic [31:0] magic_r, size_limit_r;
  logic [15:0] version_min_r, version_max_r;
  logic [7:0]  section_min_r, section_max_r;

  // Parser state
  logic [3:0]  hdr_pos_r, hdr_pos_nxt;
  logic        in_table_r, in_table_nxt;
  logic [4:0]  rec_pos_r, rec_pos_nxt;
  logic [31:0] hdr_magic_r, hdr_magic_nxt;
  logic [15:0] hdr_length_r, hdr_length_nxt;
  logic [15:0] hdr_version_r, hdr_version_nxt;
  logic [7:0]  hdr_count_r, hdr_count_nxt;
  logic [15:0] cur_type_r, cur_type_nxt;
  logic [31:0] cur_offset_r, cur_offset_nxt;
  logic [31:0] cur_size_r, cur_size_nxt;
  logic [7:0]  cur_sec_r, cur_sec_nxt;
  logic        type_err_r, type_err_nxt;
  logic        sizes_ok_r, sizes_ok_nxt;
  logic        verdict_given_r, verdict_given_nxt;

  // Step outcome
  logic         acc, proc;
  logic         rec_emit, ver_emit;
  sfhc_status_t ver_status;
  logic [15:0]  expect_len;
  logic [4:0]   off_idx, size_idx;
  logic         size_in_limit;
  sfhc_entry_t  rec_ent, ver_ent, res0, res1;
  logic [1:0]   push_cnt;

  // Result queue
  sfhc_entry_t            q_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0]   count_r;
  logic                   pop;

  assign acc       = in_tvalid && in_tready;
  assign proc      = acc && (in_tuser || !verdict_given_r);
  assign cfg_ready = 1'b1;

  // Configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r       <= MAGIC_RST;
      version_min_r <= VERSION_MIN_RST;
      version_max_r <= VERSION_MAX_RST;
      section_min_r <= SECTION_MIN_RST;
      section_max_r <= SECTION_MAX_RST;
      size_limit_r  <= SIZE_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAGIC:       magic_r       <= cfg_data;
        REG_VERSION_MIN: version_min_r <= cfg_data[15:0];
        REG_VERSION_MAX: version_max_r <= cfg_data[15:0];
        REG_SECTION_MIN: section_min_r <= cfg_data[7:0];
        REG_SECTION_MAX: section_max_r <= cfg_data[7:0];
        REG_SIZE_LIMIT:  size_limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Expected header length: 9 + 22 x count
  assign expect_len = 16'(HDR_BYTES) + {7'd0, hdr_count_nxt, 1'b0}
                    + {6'd0, hdr_count_nxt, 2'd0} + {4'd0, hdr_count_nxt, 4'd0};
  assign off_idx  = rec_pos_r - 5'd14;
  assign size_idx = rec_pos_r - 5'd18;

  // Parse one byte: advance state and decide which results it causes
  always_comb begin
    hdr_pos_nxt       = hdr_pos_r;
    in_table_nxt      = in_table_r;
    rec_pos_nxt       = rec_pos_r;
    hdr_magic_nxt     = hdr_magic_r;
    hdr_length_nxt    = hdr_length_r;
    hdr_version_nxt   = hdr_version_r;
    hdr_count_nxt     = hdr_count_r;
    cur_type_nxt      = cur_type_r;
    cur_offset_nxt    = cur_offset_r;
    cur_size_nxt      = cur_size_r;
    cur_sec_nxt       = cur_sec_r;
    type_err_nxt      = type_err_r;
    sizes_ok_nxt      = sizes_ok_r;
    verdict_given_nxt = verdict_given_r;
    rec_emit          = 1'b0;
    ver_emit          = 1'b0;
    ver_status        = ST_OK;
    size_in_limit     = 1'b1;

    if (proc) begin
      // Start of file: clear per-file state
      if (in_tuser) begin
        hdr_pos_nxt       = '0;
        in_table_nxt      = 1'b0;
        rec_pos_nxt       = '0;
        hdr_magic_nxt     = '0;
        hdr_length_nxt    = '0;
        hdr_version_nxt   = '0;
        hdr_count_nxt     = '0;
        cur_type_nxt      = '0;
        cur_offset_nxt    = '0;
        cur_size_nxt      = '0;
        cur_sec_nxt       = '0;
        type_err_nxt      = 1'b0;
        sizes_ok_nxt      = 1'b1;
        verdict_given_nxt = 1'b0;
      end

      if (!in_table_nxt) begin
        // Header byte: place into its field
        priority if (hdr_pos_nxt < 4'd4) begin
          hdr_magic_nxt[8*hdr_pos_nxt[1:0] +: 8] = in_tdata;
        end else if (hdr_pos_nxt < 4'd6) begin
          hdr_length_nxt[8*hdr_pos_nxt[0] +: 8] = in_tdata;
        end else if (hdr_pos_nxt < 4'd8) begin
          hdr_version_nxt[8*hdr_pos_nxt[0] +: 8] = in_tdata;
        end else begin
          hdr_count_nxt = in_tdata;
        end

        // Last header byte: check fields in order
        if (hdr_pos_nxt == 4'(HDR_BYTES - 1)) begin
          priority if (hdr_magic_nxt != magic_r) begin
            ver_status = ST_MAGIC;
          end else if (hdr_version_nxt < version_min_r ||
                       hdr_version_nxt > version_max_r) begin
            ver_status = ST_VERSION;
          end else if (hdr_count_nxt < section_min_r ||
                       hdr_count_nxt > section_max_r) begin
            ver_status = ST_COUNT;
          end else if (hdr_length_nxt != expect_len) begin
            ver_status = ST_HDR_SIZE;
          end else begin
            ver_status = ST_OK;
          end
          ver_emit     = (ver_status != ST_OK) || (hdr_count_nxt == 8'd0);
          in_table_nxt = 1'b1;
          rec_pos_nxt  = '0;
        end
        hdr_pos_nxt = hdr_pos_nxt + 4'd1;
      end else begin
        // Record byte: name bytes are skipped
        priority if (rec_pos_r == 5'd12) begin
          cur_type_nxt[7:0] = in_tdata;
        end else if (rec_pos_r == 5'd13) begin
          cur_type_nxt[15:8] = in_tdata;
        end else if (rec_pos_r >= 5'd14 && rec_pos_r < 5'd18) begin
          cur_offset_nxt[8*off_idx[1:0] +: 8] = in_tdata;
        end else if (rec_pos_r >= 5'd18) begin
          cur_size_nxt[8*size_idx[1:0] +: 8] = in_tdata;
        end else begin
          cur_type_nxt = cur_type_r;
        end

        // Record complete
        if (rec_pos_r == 5'(REC_BYTES - 1)) begin
          size_in_limit = (cur_size_nxt <= size_limit_r);
          rec_emit      = 1'b1;
          cur_sec_nxt   = cur_sec_r + 8'd1;
          if (!type_allowed(cur_type_nxt)) begin
            type_err_nxt = 1'b1;
          end
          if (!size_in_limit) begin
            sizes_ok_nxt = 1'b0;
          end
          if (cur_sec_nxt == hdr_count_nxt) begin
            ver_emit   = 1'b1;
            ver_status = type_err_nxt ? ST_TYPE : ST_OK;
          end
          rec_pos_nxt = '0;
        end else begin
          rec_pos_nxt = rec_pos_r + 5'd1;
        end
      end

      // Truncated file
      if (ver_emit) begin
        verdict_given_nxt = 1'b1;
      end else if (in_tlast) begin
        ver_emit          = 1'b1;
        ver_status        = ST_TRUNCATED;
        verdict_given_nxt = 1'b1;
      end
    end
  end

  // Build result items
  always_comb begin
    rec_ent                          = '0;
    rec_ent.kind                     = KIND_SECTION;
    rec_ent.last                     = !ver_emit;
    rec_ent.data.section_number      = cur_sec_nxt;
    rec_ent.data.section_kind        = cur_type_nxt;
    rec_ent.data.section_start       = cur_offset_nxt;
    rec_ent.data.section_length      = cur_size_nxt;
    rec_ent.data.status              = ST_OK;
    rec_ent.data.file_version        = hdr_version_nxt;
    rec_ent.data.section_total       = hdr_count_nxt;
    rec_ent.data.sizes_within_limit  = size_in_limit;

    ver_ent                          = '0;
    ver_ent.kind                     = KIND_VERDICT;
    ver_ent.last                     = 1'b1;
    ver_ent.data.status              = ver_status;
    ver_ent.data.file_version        = hdr_version_nxt;
    ver_ent.data.section_total       = hdr_count_nxt;
    ver_ent.data.sizes_within_limit  = sizes_ok_nxt;

    res0     = rec_emit ? rec_ent : ver_ent;
    res1     = ver_ent;
    push_cnt = {1'b0, rec_emit} + {1'b0, ver_emit};
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r       <= '0;
      in_table_r      <= 1'b0;
      rec_pos_r       <= '0;
      hdr_magic_r     <= '0;
      hdr_length_r    <= '0;
      hdr_version_r   <= '0;
      hdr_count_r     <= '0;
      cur_type_r      <= '0;
      cur_offset_r    <= '0;
      cur_size_r      <= '0;
      cur_sec_r       <= '0;
      type_err_r      <= 1'b0;
      sizes_ok_r      <= 1'b1;
      verdict_given_r <= 1'b1;
    end else begin
      hdr_pos_r       <= hdr_pos_nxt;
      in_table_r      <= in_table_nxt;
      rec_pos_r       <= rec_pos_nxt;
      hdr_magic_r     <= hdr_magic_nxt;
      hdr_length_r    <= hdr_length_nxt;
      hdr_version_r   <= hdr_version_nxt;
      hdr_count_r     <= hdr_count_nxt;
      cur_type_r      <= cur_type_nxt;
      cur_offset_r    <= cur_offset_nxt;
      cur_size_r      <= cur_size_nxt;
      cur_sec_r       <= cur_sec_nxt;
      type_err_r      <= type_err_nxt;
      sizes_ok_r      <= sizes_ok_nxt;
      verdict_given_r <= verdict_given_nxt;
    end
  end

  // Result queue: push up to two items, pop one
  assign pop        = out_tvalid && out_tready;
  assign in_tready  = (count_r <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = {{PAD_W{1'b0}}, q_mem[rd_ptr_r].data};
  assign out_tuser  = q_mem[rd_ptr_r].kind;
  assign out_tlast  = q_mem[rd_ptr_r].last;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      q_mem[wr_ptr_r] <= res0;
    end
    if (push_cnt == 2'd2) begin
      q_mem[wr_ptr_r + OUT_PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OUT_PTR_W'(push_cnt);
      rd_ptr_r <= rd_ptr_r + OUT_PTR_W'(pop);
      count_r  <= count_r + OUT_CNT_W'(push_cnt) - OUT_CNT_W'(pop);
    end
  end

  // Checks
  `SFHC_ASSERT_ALWAYS(a_queue_bound, count_r <= OUT_CNT_W'(OUT_DEPTH), "result queue overflow")
  `SFHC_ASSERT_NEXT(a_first_opens, acc && in_tuser && !in_tlast, !verdict_given_r,
                    "start byte did not open a file")
  `SFHC_ASSERT_NEXT(a_verdict_closes, proc && ver_emit, verdict_given_r,
                    "verdict did not close the file")
  `SFHC_ASSERT_NEXT(a_double_push, push_cnt == 2'd2 && !pop,
                    count_r == $past(count_r) + OUT_CNT_W'(2), "two results not both queued")
  `SFHC_ASSERT_NOW(a_idle_silent, acc && !in_tuser && verdict_given_r, push_cnt == 2'd0,
                   "result from an idle byte")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Section file header checker - testbench
// Streams byte images of section files into the checker and predicts every
// section record and verdict from its own parser. Each result is matched
// field by field against the oldest prediction, across several register
// settings, random stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import sfhc_pkg::*;

  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 16;

  // One predicted result item
  typedef struct packed {
    sfhc_kind_t   kind;
    logic [7:0]   number;
    logic [15:0]  type_code;
    logic [31:0]  start;
    logic [31:0]  rec_len;
    sfhc_status_t status;
    logic [15:0]  version;
    logic [7:0]   total;
    logic         in_limit;
    logic         last;
  } parsed_record_t;

  // Ways a random file image departs from a well-formed one
  typedef enum int {FLAW_NONE, FLAW_MAGIC, FLAW_VERSION, FLAW_COUNT, FLAW_LENGTH,
                    FLAW_NOISE} file_flaw_t;

  // Ways a random file image ends
  typedef enum int {END_FULL, END_CUT, END_ABANDON, END_TRAILING} file_end_t;

  // Parses the byte stream as the checker should and holds the predicted results
  class file_parse_tracker;
    logic [31:0] magic_cfg, limit_cfg;
    logic [15:0] ver_lo, ver_hi;
    logic [7:0]  sec_lo, sec_hi;

    logic [12:0] pos;
    logic [31:0] hdr_magic;
    logic [15:0] hdr_len, hdr_ver;
    logic [7:0]  hdr_cnt;
    logic [15:0] rec_type;
    logic [31:0] rec_offset, rec_size;
    logic [7:0]  rec_count;
    bit          bad_type_seen, sizes_ok, verdict_done;

    parsed_record_t pending_records[$];
    int errors;
    int produced;

    function new();
      magic_cfg = MAGIC_RST;
      ver_lo    = VERSION_MIN_RST;
      ver_hi    = VERSION_MAX_RST;
      sec_lo    = SECTION_MIN_RST;
      sec_hi    = SECTION_MAX_RST;
      limit_cfg = SIZE_LIMIT_RST;
      clear_file();
      verdict_done = 1'b1;
      errors   = 0;
      produced = 0;
    endfunction

    function void clear_file();
      pos           = '0;
      hdr_magic     = '0;
      hdr_len       = '0;
      hdr_ver       = '0;
      hdr_cnt       = '0;
      rec_type      = '0;
      rec_offset    = '0;
      rec_size      = '0;
      rec_count     = '0;
      bad_type_seen = 1'b0;
      sizes_ok      = 1'b1;
    endfunction

    function void set_reg(sfhc_reg_t idx, logic [31:0] v);
      case (idx)
        REG_MAGIC:       magic_cfg = v;
        REG_VERSION_MIN: ver_lo    = v[15:0];
        REG_VERSION_MAX: ver_hi    = v[15:0];
        REG_SECTION_MIN: sec_lo    = v[7:0];
        REG_SECTION_MAX: sec_hi    = v[7:0];
        REG_SIZE_LIMIT:  limit_cfg = v;
        default: ;
      endcase
    endfunction

    function void add_result(sfhc_kind_t kind, logic [7:0] number, logic [15:0] type_code,
                             logic [31:0] start, logic [31:0] rec_len,
                             sfhc_status_t status, logic in_limit);
      parsed_record_t rec;
      rec.kind      = kind;
      rec.number    = number;
      rec.type_code = type_code;
      rec.start     = start;
      rec.rec_len   = rec_len;
      rec.status    = status;
      rec.version   = hdr_ver;
      rec.total     = hdr_cnt;
      rec.in_limit  = in_limit;
      rec.last      = 1'b0;
      pending_records.push_back(rec);
      produced++;
    endfunction

    function void add_verdict(sfhc_status_t status);
      add_result(KIND_VERDICT, '0, '0, '0, '0, status, sizes_ok);
      verdict_done = 1'b1;
    endfunction

    // Advance the parser by one accepted byte
    function void parse_byte(logic [7:0] b, bit first, bit fin);
      int unsigned  p, r;
      int           queued;
      bit           in_limit, type_ok;
      sfhc_status_t st;
      logic [31:0]  need_len;
      queued = pending_records.size();
      if (first) begin
        clear_file();
        verdict_done = 1'b0;
      end
      if (verdict_done) return;
      p   = 32'(pos);
      pos = pos + 13'd1;

      if (p < HDR_BYTES) begin
        // assemble the little-endian header fields
        if (p < 4) hdr_magic |= 32'(b) << (8 * p);
        else if (p < 6) hdr_len |= 16'(b) << (8 * (p - 4));
        else if (p < 8) hdr_ver |= 16'(b) << (8 * (p - 6));
        else hdr_cnt = b;

        // check the header in priority order on its last byte
        if (p == HDR_BYTES - 1) begin
          need_len = HDR_BYTES + REC_BYTES * 32'(hdr_cnt);
          st = ST_OK;
          if (hdr_magic != magic_cfg) st = ST_MAGIC;
          else if (hdr_ver < ver_lo || hdr_ver > ver_hi) st = ST_VERSION;
          else if (hdr_cnt < sec_lo || hdr_cnt > sec_hi) st = ST_COUNT;
          else if (32'(hdr_len) != need_len) st = ST_HDR_SIZE;
          if (st != ST_OK || hdr_cnt == 8'd0) add_verdict(st);
        end
      end else begin
        // assemble one section record; the name bytes are skipped
        r = (p - HDR_BYTES) % REC_BYTES;
        if (r == 0) begin
          rec_type   = '0;
          rec_offset = '0;
          rec_size   = '0;
        end
        if (r >= 12 && r < 14) rec_type |= 16'(b) << (8 * (r - 12));
        else if (r >= 14 && r < 18) rec_offset |= 32'(b) << (8 * (r - 14));
        else if (r >= 18) rec_size |= 32'(b) << (8 * (r - 18));

        if (r == REC_BYTES - 1) begin
          in_limit  = (rec_size <= limit_cfg);
          rec_count = rec_count + 8'd1;
          type_ok   = (rec_type == TYPE_A) || (rec_type == TYPE_B) ||
                      (rec_type == TYPE_C) || (rec_type == TYPE_D) || (rec_type == TYPE_E);
          if (!type_ok) bad_type_seen = 1'b1;
          if (!in_limit) sizes_ok = 1'b0;
          add_result(KIND_SECTION, rec_count, rec_type, rec_offset, rec_size, ST_OK,
                     in_limit);
          // a bad type is only reported once the whole table is in
          if (rec_count == hdr_cnt) begin
            if (bad_type_seen) add_verdict(ST_TYPE);
            else add_verdict(ST_OK);
          end
        end
      end

      // end of file before any verdict
      if (!verdict_done && fin) add_verdict(ST_TRUNCATED);
      if (pending_records.size() > queued)
        pending_records[pending_records.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // Match one accepted result item against the oldest prediction
    function void match_record(logic [TDATA_W-1:0] data, logic user, logic last);
      sfhc_payload_t  got;
      parsed_record_t want;
      if (pending_records.size() == 0) begin
        $error("result item with no prediction waiting: tdata %0h", data);
        errors++;
        return;
      end
      want = pending_records.pop_front();
      got  = data[PAYLOAD_W-1:0];
      compare_field("record_kind", 32'(want.kind), 32'(user));
      compare_field("section_number", 32'(want.number), 32'(got.section_number));
      compare_field("section_kind", 32'(want.type_code), 32'(got.section_kind));
      compare_field("section_start", want.start, got.section_start);
      compare_field("section_length", want.rec_len, got.section_length);
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("file_version", 32'(want.version), 32'(got.file_version));
      compare_field("section_total", 32'(want.total), 32'(got.section_total));
      compare_field("sizes_within_limit", 32'(want.in_limit), 32'(got.sizes_within_limit));
      compare_field("last_of_run", 32'(want.last), 32'(last));
      compare_field("tdata padding", '0, 32'(data[TDATA_W-1:PAYLOAD_W]));
    endfunction

    function int pending();
      return pending_records.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [7:0]         in_tdata;    // [7:0] data_byte
  logic               in_tuser;    // [0] first_byte
  logic               in_tlast;    // final_byte
  logic               out_tvalid;
  logic               out_tready;
  // [7:0] section_number, [23:8] section_kind, [55:24] section_start,
  // [87:56] section_length, [90:88] status, [106:91] file_version,
  // [114:107] section_total, [115] sizes_within_limit, [119:116] zero
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tuser;   // [0] record_kind
  logic               out_tlast;   // last_of_run
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  file_parse_tracker tracker;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_requests;
  int bytes_sent;

  section_file_header_checker_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

  // Result side: match accepted items, stall at random, serve hold-off requests
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        tracker.match_record(out_tdata, out_tuser, out_tlast);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offer one byte, with random gaps ahead of it, and hold until accepted
  task automatic send_byte(input logic [7:0] b, input bit first, input bit fin);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.parse_byte(b, first, fin);
    bytes_sent++;
  endtask

  // Send the leading n_send bytes of an image; the final flag sits at fin_at
  task automatic send_image(input logic [7:0] img[$], input int n_send, input int fin_at);
    for (int i = 0; i < n_send; i++)
      send_byte(img[i], i == 0, i == fin_at);
  endtask

  function automatic void put_le(ref logic [7:0] img[$], input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) img.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_header(ref logic [7:0] img[$], input logic [31:0] magic,
                                     input logic [15:0] hlen, input logic [15:0] ver,
                                     input logic [7:0] count);
    put_le(img, magic, 4);
    put_le(img, 32'(hlen), 2);
    put_le(img, 32'(ver), 2);
    img.push_back(count);
  endfunction

  task automatic write_reg(input sfhc_reg_t idx, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, v);
  endtask

  // Write every register back to back, then drop the write channel
  task automatic load_config(input logic [31:0] magic, input logic [15:0] vmin,
                             input logic [15:0] vmax, input logic [7:0] smin,
                             input logic [7:0] smax, input logic [31:0] limit);
    write_reg(REG_MAGIC, magic);
    write_reg(REG_VERSION_MIN, 32'(vmin));
    write_reg(REG_VERSION_MAX, 32'(vmax));
    write_reg(REG_SECTION_MIN, 32'(smin));
    write_reg(REG_SECTION_MAX, 32'(smax));
    write_reg(REG_SIZE_LIMIT, limit);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait until every predicted result has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Build one file image, mostly well-formed for the current settings
  task automatic send_random_file();
    logic [7:0]  img[$];
    logic [15:0] kinds[5];
    logic [31:0] magic, rec_len;
    logic [15:0] ver, hlen;
    logic [7:0]  count;
    file_flaw_t  flaw;
    file_end_t   ending;
    int          span, n_rec, n_send, fin_at, pick;
    kinds = '{TYPE_A, TYPE_B, TYPE_C, TYPE_D, TYPE_E};

    // fields that pass the header checks where the ranges allow it
    magic = tracker.magic_cfg;
    if (tracker.ver_lo <= tracker.ver_hi)
      ver = 16'(32'(tracker.ver_lo) +
                $urandom_range(0, 32'(tracker.ver_hi) - 32'(tracker.ver_lo)));
    else
      ver = 16'($urandom);
    if (tracker.sec_lo <= tracker.sec_hi) begin
      span  = int'(tracker.sec_hi) - int'(tracker.sec_lo);
      count = 8'(32'(tracker.sec_lo) + $urandom_range(0, (span > 4) ? 4 : span));
    end else begin
      count = 8'($urandom_range(0, 4));
    end
    hlen = 16'(HDR_BYTES + REC_BYTES * 32'(count));

    // break a header field in about a third of the files
    pick = $urandom_range(0, 14);
    if (pick < 10) flaw = FLAW_NONE;
    else flaw = file_flaw_t'(pick - 9);
    case (flaw)
      FLAW_MAGIC:   magic ^= 32'd1 << $urandom_range(0, 31);
      FLAW_VERSION: ver = 16'($urandom);
      FLAW_COUNT:   count = 8'($urandom);
      FLAW_LENGTH:  hlen = 16'($urandom);
      FLAW_NOISE: begin
        magic = $urandom;
        ver   = 16'($urandom);
        count = 8'($urandom);
        hlen  = 16'($urandom);
      end
      default: ;
    endcase
    put_header(img, magic, hlen, ver, count);

    // section records: random name, mostly allowed types, sizes around the limit
    n_rec = (count > 8'd6) ? 6 : int'(count);
    for (int i = 0; i < n_rec; i++) begin
      repeat (12) img.push_back(8'($urandom));
      if ($urandom_range(0, 4) == 0) put_le(img, $urandom, 2);
      else put_le(img, 32'(kinds[$urandom_range(0, 4)]), 2);
      put_le(img, $urandom, 4);
      case ($urandom_range(0, 5))
        0: rec_len = tracker.limit_cfg;
        1: rec_len = tracker.limit_cfg + 32'd1;
        2: rec_len = tracker.limit_cfg - 32'd1;
        3: rec_len = $urandom_range(0, 255);
        default: rec_len = $urandom;
      endcase
      put_le(img, rec_len, 4);
    end

    // choose how the file ends
    pick = $urandom_range(0, 9);
    if (pick < 6) ending = END_FULL;
    else ending = file_end_t'(pick - 5 > 3 ? 3 : pick - 5);
    n_send = img.size();
    fin_at = n_send - 1;
    case (ending)
      END_CUT: begin
        n_send = $urandom_range(1, img.size());
        fin_at = n_send - 1;
      end
      END_ABANDON: begin
        n_send = $urandom_range(1, img.size());
        fin_at = -1;
      end
      END_TRAILING: begin
        repeat ($urandom_range(1, 3)) img.push_back(8'($urandom));
        n_send = img.size();
        fin_at = $urandom_range(fin_at, n_send - 1);
      end
      default: ;
    endcase
    send_image(img, n_send, fin_at);
  endtask

  // Random files, with stray bytes between them, until both goals are met or 60 files have been sent
  task automatic random_files(input int byte_goal, input int result_goal);
    int start_bytes, start_results, files;
    start_bytes   = bytes_sent;
    start_results = tracker.produced;
    files         = 0;
    while ((bytes_sent - start_bytes < byte_goal ||
            tracker.produced - start_results < result_goal) && files < 60) begin
      if ($urandom_range(0, 7) == 0)
        send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
      send_random_file();
      files++;
    end
  endtask

  // Main sequence
  initial begin
    logic [7:0]  img[$];
    logic [15:0] vlo;
    tracker       = new();
    hold_requests = 0;
    bytes_sent    = 0;
    tx_idle_pct   = 14;
    rx_idle_pct   = 69;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_MAGIC;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, but let an empty table through
    load_config(MAGIC_RST, VERSION_MIN_RST, VERSION_MAX_RST, 8'd0, SECTION_MAX_RST,
                SIZE_LIMIT_RST);

    // byte ignored while idle, before any start-of-file flag
    send_byte(8'hFF, 1'b0, 1'b1);
    // one-byte file: truncated with nothing assembled
    send_byte(8'h00, 1'b1, 1'b1);
    // empty table accepted on the last header byte, then a trailing byte
    put_header(img, MAGIC_RST, 16'(HDR_BYTES), VERSION_MIN_RST, 8'd0);
    img.push_back(8'hA5);
    send_image(img, img.size(), img.size() - 1);
    // all-ones header fails on the magic word
    img.delete();
    put_header(img, '1, '1, '1, 8'hFF);
    send_image(img, img.size(), img.size() - 1);
    // header cut after the length field, before the version field
    img.delete();
    put_header(img, MAGIC_RST, 16'(HDR_BYTES), VERSION_MAX_RST, 8'd0);
    send_image(img, 6, 5);
    drain();

    // ordinary ranges, sender mostly busy, receiver mostly stalled
    vlo = 16'($urandom_range(0, 1000));
    load_config($urandom, vlo, vlo + 16'($urandom_range(0, 3000)), 8'd1, 8'd4,
                $urandom_range(100, 5000));
    random_files(90, 4);
    drain();

    // widest ranges and a zero size limit, roles of the two sides swapped
    tx_idle_pct = 69;
    rx_idle_pct = 14;
    load_config('1, 16'h0000, 16'hFFFF, 8'h00, 8'hFF, 32'h0);
    random_files(90, 4);
    drain();

    // empty ranges reject every version and count; no idling from here on
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_config(32'h0, 16'hFFFF, 16'h0000, 8'hFF, 8'h00, 32'hFFFF_FFFF);
    random_files(50, 2);

    // hold the output off while one-byte files keep arriving, to back up the input
    hold_requests++;
    repeat (20) send_byte(8'($urandom), 1'b1, 1'b1);
    drain();

    // single-value ranges
    load_config(MAGIC_RST, 16'd100, 16'd100, 8'd2, 8'd2, 32'h8000_0000);
    random_files(90, 4);
    drain();

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/sfhc_pkg.sv
src/section_file_header_checker_core.sv
dv/tb.sv
